@@ rtl/xdme_pkg.sv @@
// Shared types and constants for the XOR decrypt / end marker extract block.
`timescale 1ns / 1ps

package xdme_pkg;

    // Default marker window depth and front/back queue depth
    localparam int MAX_MARKER_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes
    localparam logic [1:0] REG_KEY_FOLD      = 2'd0;
    localparam logic [1:0] REG_START_OFFSET  = 2'd1;
    localparam logic [1:0] REG_MARKER_BYTES  = 2'd2;
    localparam logic [1:0] REG_MARKER_LENGTH = 2'd3;

    // What a queued word asks the back end to do
    typedef enum logic {
        KIND_DATA,
        KIND_OFS_END
    } t_kind;

    // End status codes
    typedef enum logic [1:0] {
        STAT_FOUND     = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_OFS_END   = 2'd2
    } t_status;

    // Back end sequencing
    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_back_state;

    // One queued word from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_entry;

endpackage

@@ rtl/xdme_front.sv @@
// Front end: offset skipping, key XOR and classification of input words.
`timescale 1ns / 1ps

module xdme_front
    import xdme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte
    input  logic        i_s_tlast,   // in_last
    input  logic [7:0]  i_key_fold,
    input  logic [31:0] i_start_offset,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [31:0] r_skip;
    logic        r_any_data;
    logic [31:0] n_skip;
    logic        n_any_data;
    logic        skip;
    logic        accept;

    // Still inside the leading offset region
    assign skip       = !r_any_data && (r_skip < i_start_offset);
    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && !i_full;

    // Skipped words are dropped unless they end the stream
    assign o_push        = accept && (!skip || i_s_tlast);
    assign o_entry.kind  = skip ? KIND_OFS_END : KIND_DATA;
    assign o_entry.data  = skip ? 8'd0 : (i_s_tdata ^ i_key_fold);
    assign o_entry.last  = i_s_tlast;

    // Skip tracking, rearmed by the final word of a stream
    always_comb begin
        n_skip     = r_skip;
        n_any_data = r_any_data;
        if (accept) begin
            if (i_s_tlast) begin
                n_skip     = 32'd0;
                n_any_data = 1'b0;
            end else if (skip) begin
                n_skip = r_skip + 32'd1;
            end else begin
                n_any_data = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip     <= 32'd0;
            r_any_data <= 1'b0;
        end else begin
            r_skip     <= n_skip;
            r_any_data <= n_any_data;
        end
    end

endmodule

@@ rtl/xdme_queue.sv @@
// Short register queue between front and back end.
`timescale 1ns / 1ps

module xdme_queue
    import xdme_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_head_valid,
    output t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!do_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ rtl/xdme_back.sv @@
// Back end: match window, marker compare, byte emission and output register.
`timescale 1ns / 1ps

module xdme_back
    import xdme_pkg::*;
#(
    parameter int MAX_MARKER = MAX_MARKER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_entry      i_head,
    output logic        o_pop,
    input  logic [63:0] i_marker_bytes,
    input  logic [3:0]  i_marker_length,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // data_byte
    output logic        o_m_tlast,   // end_of_message
    output logic [2:0]  o_m_tuser    // byte_valid, status[1:0]
);

    localparam int FW = $clog2(MAX_MARKER + 1);

    t_back_state r_state;
    t_back_state n_state;
    logic [7:0]  r_win [MAX_MARKER];
    logic [7:0]  n_win [MAX_MARKER];
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic        r_seen;
    logic        n_seen;

    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_bvalid;
    logic        r_out_eom;
    t_status     r_out_status;

    logic        e_valid;
    logic [7:0]  e_data;
    logic        e_bvalid;
    logic        e_eom;
    t_status     e_status;

    logic [FW-1:0] len;
    logic          out_free;
    logic          go;
    logic          popping;
    logic          final_pop;
    logic [FW-1:0] bfill;
    logic [7:0]    shifted [MAX_MARKER];
    logic [7:0]    cand [MAX_MARKER];
    logic          match;
    logic          cmp_ok;

    // Marker length clamped to 1..MAX_MARKER
    always_comb begin
        if (i_marker_length == 4'd0) begin
            len = FW'(1);
        end else if (i_marker_length > 4'(MAX_MARKER)) begin
            len = FW'(MAX_MARKER);
        end else begin
            len = i_marker_length[FW-1:0];
        end
    end

    assign out_free  = !r_out_valid || i_m_tready;
    assign go        = i_head_valid && out_free;
    assign popping   = (r_fill >= len);
    assign final_pop = (r_fill == len);
    assign bfill     = popping ? (r_fill - FW'(1)) : r_fill;

    // Window after one pop, and after the incoming word is appended
    always_comb begin
        for (int i = 0; i < MAX_MARKER; i++) begin
            shifted[i] = (i < MAX_MARKER - 1) ? r_win[(i + 1) % MAX_MARKER] : 8'd0;
        end
        for (int i = 0; i < MAX_MARKER; i++) begin
            cand[i] = popping ? shifted[i] : r_win[i];
            if (FW'(i) == bfill) begin
                cand[i] = i_head.data;
            end
        end
    end

    // Parallel marker compare over the low len bytes
    always_comb begin
        cmp_ok = 1'b1;
        for (int i = 0; i < MAX_MARKER; i++) begin
            if ((FW'(i) < len) && (cand[i] != i_marker_bytes[8*i +: 8])) begin
                cmp_ok = 1'b0;
            end
        end
        match = cmp_ok && ((bfill + FW'(1)) == len);
    end

    // Next state: a final word without match drains the window
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (go && i_head.kind == KIND_DATA && !r_seen
                    && (!popping || final_pop) && !match && i_head.last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (go && r_fill == FW'(1)) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // Window update, queue pop and emitted word
    always_comb begin
        n_win    = r_win;
        n_fill   = r_fill;
        n_seen   = r_seen;
        o_pop    = 1'b0;
        e_valid  = 1'b0;
        e_data   = 8'd0;
        e_bvalid = 1'b0;
        e_eom    = 1'b0;
        e_status = STAT_FOUND;
        if (go) begin
            case (r_state)
                ST_RUN: begin
                    if (i_head.kind == KIND_OFS_END) begin
                        e_valid  = 1'b1;
                        e_eom    = 1'b1;
                        e_status = STAT_OFS_END;
                        n_fill   = '0;
                        n_seen   = 1'b0;
                        o_pop    = 1'b1;
                    end else if (r_seen) begin
                        o_pop = 1'b1;
                        if (i_head.last) begin
                            n_fill = '0;
                            n_seen = 1'b0;
                        end
                    end else if (popping && !final_pop) begin
                        // window longer than marker: drain one oldest byte
                        e_valid  = 1'b1;
                        e_data   = r_win[0];
                        e_bvalid = 1'b1;
                        n_win    = shifted;
                        n_fill   = r_fill - FW'(1);
                    end else begin
                        // append the word, emitting the oldest if window is full
                        n_win  = cand;
                        n_fill = bfill + FW'(1);
                        if (popping) begin
                            e_valid  = 1'b1;
                            e_data   = r_win[0];
                            e_bvalid = 1'b1;
                        end
                        if (match) begin
                            e_valid = 1'b1;
                            e_eom   = 1'b1;
                            o_pop   = 1'b1;
                            if (i_head.last) begin
                                n_fill = '0;
                                n_seen = 1'b0;
                            end else begin
                                n_seen = 1'b1;
                            end
                        end else if (!i_head.last) begin
                            o_pop = 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    e_valid  = 1'b1;
                    e_data   = r_win[0];
                    e_bvalid = 1'b1;
                    n_win    = shifted;
                    n_fill   = r_fill - FW'(1);
                    if (r_fill == FW'(1)) begin
                        e_eom    = 1'b1;
                        e_status = STAT_NOT_FOUND;
                        n_fill   = '0;
                        n_seen   = 1'b0;
                        o_pop    = 1'b1;
                    end
                end
                default: begin
                    n_fill = '0;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_fill      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_seen  <= n_seen;
            if (out_free) begin
                r_out_valid <= e_valid;
            end
        end
    end

    // Window bytes and output word
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (out_free) begin
            r_out_data   <= e_data;
            r_out_bvalid <= e_bvalid;
            r_out_eom    <= e_eom;
            r_out_status <= e_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_eom;
    assign o_m_tuser  = {r_out_status, r_out_bvalid};

endmodule

@@ rtl/xor_decrypt_marker_extract.sv @@
// XOR decrypt / end marker extract: top level with configuration registers.
// Path: an accepted input word is written into the queue, then the back end registers the result word.
// Throughput: one byte per cycle while i_m_tready is high; each extra window byte drained
//   after a marker length cut, and each byte flushed at stream end, is emitted without a new input byte.
// Reset: synchronous active-low i_rst_n clears skip, window and queue state,
//   sets key_fold, start_offset, marker_bytes to 0 and marker_length to 1.
`timescale 1ns / 1ps

module xor_decrypt_marker_extract
    import xdme_pkg::*;
#(
    parameter int MAX_MARKER  = MAX_MARKER_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // in_byte
    input  logic        i_s_tlast,   // in_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // data_byte
    output logic        o_m_tlast,   // end_of_message
    output logic [2:0]  o_m_tuser,   // byte_valid, status[1:0]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata
);

    logic [7:0]  r_key_fold;
    logic [31:0] r_start_offset;
    logic [63:0] r_marker_bytes;
    logic [3:0]  r_marker_length;

    logic   push;
    t_entry push_entry;
    logic   full;
    logic   pop;
    logic   head_valid;
    t_entry head;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_fold      <= 8'd0;
            r_start_offset  <= 32'd0;
            r_marker_bytes  <= 64'd0;
            r_marker_length <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_KEY_FOLD:      r_key_fold      <= i_cfg_wdata[7:0];
                REG_START_OFFSET:  r_start_offset  <= i_cfg_wdata[31:0];
                REG_MARKER_BYTES:  r_marker_bytes  <= i_cfg_wdata;
                REG_MARKER_LENGTH: r_marker_length <= i_cfg_wdata[3:0];
                default:           r_key_fold      <= r_key_fold;
            endcase
        end
    end

    xdme_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tlast      (i_s_tlast),
        .i_key_fold     (r_key_fold),
        .i_start_offset (r_start_offset),
        .i_full         (full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    xdme_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    xdme_back #(
        .MAX_MARKER (MAX_MARKER)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .i_marker_bytes  (r_marker_bytes),
        .i_marker_length (r_marker_length),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_m_tdata       (o_m_tdata),
        .o_m_tlast       (o_m_tlast),
        .o_m_tuser       (o_m_tuser)
    );

endmodule
